FILE: rtl/core/bpatm_pkg.sv
// bpatm_pkg: shared types and constants for the bit-parallel approximate matcher.
// Used by every module under rtl/core but bpatm_ram; depends on nothing.
`default_nettype none

package bpatm_pkg;

	localparam int MASK_W      = 64;
	localparam int SRC_W       = $clog2(MASK_W);
	localparam int CODE_W      = 8;
	localparam int POS_W       = 32;
	localparam int K_W         = 6;
	localparam int M_W         = 7;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 8;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 40;
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH) + 1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd1;

	localparam logic [K_W-1:0] K_RESET = 6'd1;
	localparam logic [M_W-1:0] M_RESET = 7'd4;

	typedef enum logic [1:0] {
		CFG_IDLE,
		CFG_SETUP,
		CFG_BUILD,
		CFG_FIN
	} cfg_state_t;

	typedef struct packed {
		logic busy;
		logic clr_pos;
		logic load_din;
		logic bad;
	} cfg_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/bit_parallel_approx_text_match.sv
// bit_parallel_approx_text_match: top level of the approximate text matcher.
// Depends on bpatm_pkg, bpatm_cfg, bpatm_front, bpatm_queue, bpatm_back.
//
// Usage:
//   s_* carries one item per beat: s_tuser is the op (0 load a character's
//   accept mask, 1 feed one text character); s_tdata holds char_code in
//   [7:0] and accept_mask in [71:8] (ignored for text).
//   m_* returns one result per item, in order: m_tdata holds match [0],
//   end_position [32:1] (0 for loads) and config_bad [33].
//   cfg_* writes register cfg_index (0 max_errors, 1 pattern_length) with
//   cfg_data; other indexes are taken and ignored.
// An item goes through the table read and gather stages, the queue and the
// output register. One item per cycle is sustained while m_tready is high
// and the builder is idle; the back stage does the diagonal add-and-mask.
// After reset and after each register write the mask builder runs setup,
// builds the pattern_length - max_errors diagonal blocks, one per cycle
// (none for a bad geometry), and finishes, with s_tready and cfg_ready low.
// Reset clears the position and leaves every character matching nothing.
// When m_tready is low, results collect in a four-entry queue; s_tready
// drops once the queue and the two front stages hold four beats together.
`default_nettype none

module bit_parallel_approx_text_match #(
	parameter int WORD_BITS = 64,
	parameter int ALPHABET  = 128
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [bpatm_pkg::IN_DATA_W-1:0]      s_tdata,   // char_code, accept_mask
	input  wire logic                                 s_tuser,   // op
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [bpatm_pkg::OUT_DATA_W-1:0]     m_tdata,   // match, end_position, config_bad
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bpatm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bpatm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int POS_W = bpatm_pkg::POS_W;
	localparam int Q_W   = 1 + POS_W + WORD_BITS;

	bpatm_pkg::cfg_ctrl_t ctrl;

	logic [bpatm_pkg::M_W-1:0] bw;
	logic [WORD_BITS-1:0]      m1;
	logic [WORD_BITS-1:0]      m2;
	logic [WORD_BITS-1:0]      din;
	logic [WORD_BITS-1:0]      g;
	logic [WORD_BITS-1:0][bpatm_pkg::SRC_W-1:0] src;

	logic                          push;
	logic                          push_op;
	logic [POS_W-1:0]              push_pos;
	logic [WORD_BITS-1:0]          push_pkd;
	logic                          pop;
	logic [Q_W-1:0]                q_data;
	logic [bpatm_pkg::Q_CNT_W-1:0] q_count;
	logic                          q_empty;

	bpatm_cfg #(
		.WORD_BITS(WORD_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.bw       (bw),
		.m1       (m1),
		.m2       (m2),
		.din      (din),
		.g        (g),
		.src      (src)
	);

	bpatm_front #(
		.WORD_BITS(WORD_BITS),
		.ALPHABET (ALPHABET)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.ctrl    (ctrl),
		.din     (din),
		.src     (src),
		.q_count (q_count),
		.push    (push),
		.push_op (push_op),
		.push_pos(push_pos),
		.push_pkd(push_pkd)
	);

	bpatm_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_op, push_pos, push_pkd}),
		.pop      (pop),
		.pop_data (q_data),
		.count    (q_count),
		.empty    (q_empty)
	);

	bpatm_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.bw      (bw),
		.m1      (m1),
		.m2      (m2),
		.din     (din),
		.g       (g),
		.q_empty (q_empty),
		.q_op    (q_data[Q_W-1]),
		.q_pos   (q_data[WORD_BITS +: POS_W]),
		.q_pkd   (q_data[WORD_BITS-1:0]),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire

FILE: rtl/core/bpatm_ram.sv
// bpatm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpatm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/bpatm_cfg.sv
// bpatm_cfg: config registers and the sequencer that builds the packed masks
// (M1, M2, Din, G) and the per-bit gather map. Depends on bpatm_pkg.
`default_nettype none

module bpatm_cfg #(
	parameter int WORD_BITS = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [bpatm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [bpatm_pkg::CFG_DATA_W-1:0]       cfg_data,
	output bpatm_pkg::cfg_ctrl_t                        ctrl,
	output logic      [bpatm_pkg::M_W-1:0]              bw,
	output logic      [WORD_BITS-1:0]                   m1,
	output logic      [WORD_BITS-1:0]                   m2,
	output logic      [WORD_BITS-1:0]                   din,
	output logic      [WORD_BITS-1:0]                   g,
	output logic      [WORD_BITS-1:0][bpatm_pkg::SRC_W-1:0] src
);

	localparam int M_W = bpatm_pkg::M_W;
	localparam int K_W = bpatm_pkg::K_W;
	localparam int P_W = 2 * M_W;

	bpatm_pkg::cfg_state_t state_q, state_nxt;

	logic [K_W-1:0]       k_q;
	logic [M_W-1:0]       m_q;
	logic                 bad_q;
	logic [M_W-1:0]       bc_q;
	logic [M_W-1:0]       bw_q;
	logic [M_W-1:0]       blk_q;
	logic [M_W-1:0]       base_q;
	logic [WORD_BITS-1:0] m1_q;
	logic [WORD_BITS-1:0] m3_q;
	logic [WORD_BITS-1:0] din_q;
	logic [WORD_BITS-1:0] g_q;
	logic [WORD_BITS-1:0][bpatm_pkg::SRC_W-1:0] src_q;

	logic                 cfg_fire;
	logic                 reg_hit;
	logic [M_W-1:0]       k_ext;
	logic [M_W-1:0]       diff;
	logic [P_W-1:0]       prod;
	logic                 bad_calc;
	logic [WORD_BITS-1:0] in_blk;
	logic [WORD_BITS-1:0] blk_head;
	logic [WORD_BITS-1:0][M_W-1:0] off;

	assign cfg_fire = cfg_valid && cfg_ready;
	assign reg_hit  = cfg_fire && (cfg_index == bpatm_pkg::REG_MAX_ERRORS ||
		cfg_index == bpatm_pkg::REG_PATTERN_LENGTH);

	assign k_ext    = {1'b0, k_q};
	assign diff     = m_q - k_ext;
	assign prod     = P_W'(diff) * P_W'(k_ext + 7'd2);
	assign bad_calc = (m_q == '0) || (k_ext >= m_q) || (prod > P_W'(WORD_BITS));

	// one block of the diagonal word per cycle
	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			in_blk[p]   = (8'(p) >= {1'b0, base_q}) &&
				(8'(p) <= ({1'b0, base_q} + {2'b0, k_q}));
			blk_head[p] = (8'(p) == {1'b0, base_q});
			off[p]      = bc_q - 7'd1 - blk_q + 7'(p) - base_q;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bpatm_pkg::CFG_IDLE: begin
				if (reg_hit) begin
					state_nxt = bpatm_pkg::CFG_SETUP;
				end
			end
			bpatm_pkg::CFG_SETUP: begin
				state_nxt = bad_calc ? bpatm_pkg::CFG_FIN : bpatm_pkg::CFG_BUILD;
			end
			bpatm_pkg::CFG_BUILD: begin
				if (blk_q == bc_q - 7'd1) begin
					state_nxt = bpatm_pkg::CFG_FIN;
				end
			end
			bpatm_pkg::CFG_FIN: begin
				state_nxt = bpatm_pkg::CFG_IDLE;
			end
			default: begin
				state_nxt = bpatm_pkg::CFG_IDLE;
			end
		endcase
	end

	always_comb begin
		cfg_ready     = 1'b0;
		ctrl.load_din = 1'b0;
		case (state_q)
			bpatm_pkg::CFG_IDLE: begin
				cfg_ready = 1'b1;
			end
			bpatm_pkg::CFG_FIN: begin
				ctrl.load_din = 1'b1;
			end
			default: begin
				cfg_ready     = 1'b0;
				ctrl.load_din = 1'b0;
			end
		endcase
		ctrl.busy    = (state_q != bpatm_pkg::CFG_IDLE) || cfg_valid;
		ctrl.clr_pos = reg_hit;
		ctrl.bad     = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpatm_pkg::CFG_SETUP;
			k_q     <= bpatm_pkg::K_RESET;
			m_q     <= bpatm_pkg::M_RESET;
			bad_q   <= 1'b0;
			bc_q    <= '0;
			bw_q    <= '0;
			blk_q   <= '0;
			base_q  <= '0;
			m1_q    <= '0;
			m3_q    <= '0;
			din_q   <= '0;
			g_q     <= '0;
			src_q   <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				bpatm_pkg::CFG_IDLE: begin
					if (cfg_fire && cfg_index == bpatm_pkg::REG_MAX_ERRORS) begin
						k_q <= cfg_data[K_W-1:0];
					end
					if (cfg_fire && cfg_index == bpatm_pkg::REG_PATTERN_LENGTH) begin
						m_q <= cfg_data[M_W-1:0];
					end
				end
				bpatm_pkg::CFG_SETUP: begin
					bad_q  <= bad_calc;
					bc_q   <= diff;
					bw_q   <= k_ext + 7'd2;
					blk_q  <= '0;
					base_q <= '0;
					m1_q   <= '0;
					din_q  <= '0;
					src_q  <= '0;
					m3_q   <= bad_calc ? '0 :
						((WORD_BITS'(1) << (k_ext + 7'd1)) - WORD_BITS'(1));
					g_q    <= bad_calc ? '0 : (WORD_BITS'(1) << k_q);
				end
				bpatm_pkg::CFG_BUILD: begin
					for (int p = 0; p < WORD_BITS; p++) begin
						if (in_blk[p]) begin
							din_q[p] <= 1'b1;
							src_q[p] <= off[p][bpatm_pkg::SRC_W-1:0];
						end
						if (blk_head[p]) begin
							m1_q[p] <= 1'b1;
						end
					end
					blk_q  <= blk_q + 7'd1;
					base_q <= base_q + bw_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign bw  = bw_q;
	assign m1  = m1_q;
	assign m2  = m1_q | m3_q;
	assign din = din_q;
	assign g   = g_q;
	assign src = src_q;

	a_build_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bpatm_pkg::CFG_BUILD |-> blk_q < bc_q)
		else $error("block counter ran past block count");

endmodule

`default_nettype wire

FILE: rtl/core/bpatm_front.sv
// bpatm_front: accepts beats, writes and reads the mismatch table, and gathers
// the table word into diagonal-packed form. Depends on bpatm_pkg, bpatm_ram.
`default_nettype none

module bpatm_front #(
	parameter int WORD_BITS = 64,
	parameter int ALPHABET  = 128
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       s_tvalid,
	output logic                                            s_tready,
	input  wire logic [bpatm_pkg::IN_DATA_W-1:0]            s_tdata,
	input  wire logic                                       s_tuser,
	input  wire bpatm_pkg::cfg_ctrl_t                       ctrl,
	input  wire logic [WORD_BITS-1:0]                       din,
	input  wire logic [WORD_BITS-1:0][bpatm_pkg::SRC_W-1:0] src,
	input  wire logic [bpatm_pkg::Q_CNT_W-1:0]              q_count,
	output logic                                            push,
	output logic                                            push_op,
	output logic      [bpatm_pkg::POS_W-1:0]                push_pos,
	output logic      [WORD_BITS-1:0]                       push_pkd
);

	localparam int AW     = $clog2(ALPHABET);
	localparam int MASK_W = bpatm_pkg::MASK_W;
	localparam int CODE_W = bpatm_pkg::CODE_W;
	localparam int POS_W  = bpatm_pkg::POS_W;
	localparam int CNT_W  = bpatm_pkg::Q_CNT_W;

	logic [ALPHABET-1:0] valid_q;
	logic [POS_W-1:0]    pos_q;

	logic                v_s1;
	logic                op_s1;
	logic                hit_s1;
	logic [POS_W-1:0]    pos_s1;
	logic                v_s2;
	logic                op_s2;
	logic [POS_W-1:0]    pos_s2;
	logic [WORD_BITS-1:0] pkd_s2;

	logic                in_fire;
	logic [CODE_W-1:0]   code;
	logic [MASK_W-1:0]   amask;
	logic                in_rng;
	logic [AW-1:0]       addr;
	logic                tbl_we;
	logic [MASK_W-1:0]   rdata;
	logic [MASK_W-1:0]   f_s1;
	logic [WORD_BITS-1:0] pkd_c;
	logic [CNT_W-1:0]    used;
	logic [POS_W-1:0]    pos_inc;

	// queue entries plus items still in the two front stages
	assign used     = q_count + CNT_W'(v_s1) + CNT_W'(v_s2);
	assign s_tready = !ctrl.busy && (used < CNT_W'(bpatm_pkg::QUEUE_DEPTH));
	assign in_fire  = s_tvalid && s_tready;

	assign code    = s_tdata[CODE_W-1:0];
	assign amask   = s_tdata[CODE_W +: MASK_W];
	assign in_rng  = {1'b0, code} < 9'(ALPHABET);
	assign addr    = in_rng ? code[AW-1:0] : '0;
	assign tbl_we  = in_fire && (s_tuser == bpatm_pkg::OP_LOAD) && in_rng;
	assign pos_inc = pos_q + 32'd1;

	bpatm_ram #(
		.WIDTH(MASK_W),
		.DEPTH(ALPHABET)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(addr),
		.wdata(~amask),
		.re   (in_fire),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pos_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (tbl_we) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctrl.clr_pos) begin
				pos_q <= '0;
			end else if (in_fire && s_tuser == bpatm_pkg::OP_TEXT) begin
				pos_q <= pos_inc;
			end
			v_s1 <= in_fire;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= s_tuser;
			hit_s1 <= in_rng && valid_q[addr];
			pos_s1 <= (s_tuser == bpatm_pkg::OP_TEXT) ? pos_inc : '0;
		end
		op_s2  <= op_s1;
		pos_s2 <= pos_s1;
		pkd_s2 <= pkd_c;
	end

	// unwritten entries and codes outside the alphabet match nothing
	assign f_s1 = hit_s1 ? rdata : '1;

	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			pkd_c[p] = din[p] & f_s1[src[p]];
		end
	end

	assign push     = v_s2;
	assign push_op  = op_s2;
	assign push_pos = pos_s2;
	assign push_pkd = pkd_s2;

endmodule

`default_nettype wire

FILE: rtl/core/bpatm_queue.sv
// bpatm_queue: short FIFO between the front and back halves.
// Depends on bpatm_pkg for its depth.
`default_nettype none

module bpatm_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [WIDTH-1:0]              push_data,
	input  wire logic                          pop,
	output logic      [WIDTH-1:0]              pop_data,
	output logic      [bpatm_pkg::Q_CNT_W-1:0] count,
	output logic                               empty
);

	localparam int DEPTH = bpatm_pkg::QUEUE_DEPTH;
	localparam int PW    = bpatm_pkg::Q_PTR_W;
	localparam int CW    = bpatm_pkg::Q_CNT_W;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign pop_data = mem_q[rp_q];
	assign count    = cnt_q;
	assign empty    = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != CW'(DEPTH)) || pop)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue underflow");

endmodule

`default_nettype wire

FILE: rtl/core/bpatm_back.sv
// bpatm_back: diagonal-word update and the output register.
// Depends on bpatm_pkg.
`default_nettype none

module bpatm_back #(
	parameter int WORD_BITS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bpatm_pkg::cfg_ctrl_t             ctrl,
	input  wire logic [bpatm_pkg::M_W-1:0]        bw,
	input  wire logic [WORD_BITS-1:0]             m1,
	input  wire logic [WORD_BITS-1:0]             m2,
	input  wire logic [WORD_BITS-1:0]             din,
	input  wire logic [WORD_BITS-1:0]             g,
	input  wire logic                             q_empty,
	input  wire logic                             q_op,
	input  wire logic [bpatm_pkg::POS_W-1:0]      q_pos,
	input  wire logic [WORD_BITS-1:0]             q_pkd,
	output logic                                  pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [bpatm_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int POS_W = bpatm_pkg::POS_W;
	localparam int PAD_W = bpatm_pkg::OUT_DATA_W - POS_W - 2;

	logic [WORD_BITS-1:0] dw_q;
	logic                 m_tvalid_q;
	logic                 match_q;
	logic [POS_W-1:0]     epos_q;
	logic                 bad_q;

	logic                 is_text;
	logic                 upd;
	logic [WORD_BITS-1:0] x;
	logic [WORD_BITS-1:0] sum;
	logic [WORD_BITS-1:0] d_new;

	assign pop     = !q_empty && (!m_tvalid_q || m_tready);
	assign is_text = (q_op == bpatm_pkg::OP_TEXT);
	assign upd     = pop && is_text && !ctrl.bad;

	assign x     = (dw_q >> bw) | q_pkd;
	assign sum   = x + m1;
	assign d_new = ((dw_q << 1) | m1) & ((dw_q << ({1'b0, bw} + 8'd1)) | m2) &
		((sum ^ x) >> 1) & din;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.load_din) begin
				dw_q <= din;
			end else if (upd) begin
				dw_q <= d_new;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			match_q <= is_text && !ctrl.bad && ((d_new & g) == '0);
			epos_q  <= q_pos;
			bad_q   <= ctrl.bad;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {PAD_W'(0), bad_q, epos_q, match_q};

	a_no_match_bad_geom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(match_q && bad_q))
		else $error("match reported with unusable geometry");

endmodule

`default_nettype wire
